### hdl/grdc_pkg.sv
`timescale 1ns / 1ps
package grdc_pkg;

   localparam int FULL_SCALE = 32767;
   localparam int TRIG_MAX   = 255;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 15;

   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_DZ  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_DZ = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIG_THR = 2'd2;

   localparam logic [14:0] LEFT_DZ_RESET  = 15'd7849;
   localparam logic [14:0] RIGHT_DZ_RESET = 15'd8689;
   localparam logic [7:0]  TRIG_THR_RESET = 8'd30;

   typedef struct packed {
      logic               present;
      logic signed [15:0] raw_left_x;
      logic signed [15:0] raw_left_y;
      logic signed [15:0] raw_right_x;
      logic signed [15:0] raw_right_y;
      logic [7:0]         raw_left_trigger;
      logic [7:0]         raw_right_trigger;
      logic [15:0]        raw_buttons;
   } req_type;

   typedef struct packed {
      logic               connected;
      logic signed [15:0] left_x;
      logic signed [15:0] left_y;
      logic signed [15:0] right_x;
      logic signed [15:0] right_y;
      logic [14:0]        left_trigger;
      logic [14:0]        right_trigger;
      logic [15:0]        buttons;
      logic               changed;
   } rsp_type;

   typedef struct packed {
      logic start;
   } lane_ctl_type;

   typedef struct packed {
      logic done;
      logic active;
   } lane_sts_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_OUT
   } top_state_type;

   typedef enum logic [2:0] {
      SL_IDLE,
      SL_SQRT,
      SL_DEN,
      SL_DIVX,
      SL_DIVY,
      SL_DONE
   } stick_state_type;

endpackage

### hdl/grdc_if.sv
`timescale 1ns / 1ps
interface grdc_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### hdl/grdc_divider.sv
`timescale 1ns / 1ps
module grdc_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [45:0] dividend,
   input  logic [30:0] divisor,
   output logic        busy,
   output logic [45:0] quotient
);
   logic [5:0]  count_ff, count_in;
   logic [45:0] quot_ff, quot_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] trial;
   logic [32:0] diff;

   always_comb begin
      trial = {rem_ff[30:0], quot_ff[45]};
      diff = {1'b0, trial} - {2'b00, divisor};
      count_in = count_ff;
      quot_in = quot_ff;
      rem_in = rem_ff;
      if (start) begin
         count_in = 6'd46;
         quot_in = dividend;
         rem_in = '0;
      end else if (count_ff != 6'd0) begin
         count_in = count_ff - 6'd1;
         if (!diff[32]) begin
            rem_in = diff[31:0];
            quot_in = {quot_ff[44:0], 1'b1};
         end else begin
            rem_in = trial;
            quot_in = {quot_ff[44:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      quot_ff <= quot_in;
      rem_ff <= rem_in;
   end

   assign busy = (count_ff != 6'd0);
   assign quotient = quot_ff;
endmodule

### hdl/grdc_stick_lane.sv
`timescale 1ns / 1ps
module grdc_stick_lane (
   input  logic                        clock,
   input  logic                        reset,
   input  grdc_pkg::lane_ctl_type      ctl,
   input  logic signed [15:0]          x,
   input  logic signed [15:0]          y,
   input  logic [14:0]                 deadzone,
   output grdc_pkg::lane_sts_type      sts,
   output logic signed [15:0]          out_x,
   output logic signed [15:0]          out_y
);
   import grdc_pkg::*;

   stick_state_type state_ff, state_in;
   logic [15:0] mag_x_ff, mag_y_ff;
   logic        neg_x_ff, neg_y_ff;
   logic [31:0] sq_x, sq_y;
   logic [32:0] sum_ff;
   logic [29:0] dz_sq;
   logic        active_ff, zero_ff;
   logic [33:0] rem_ff, rem_in;
   logic [16:0] root_ff, root_in;
   logic [4:0]  step_ff;
   logic [35:0] trial;
   logic [14:0] dz_ff;
   logic [30:0] num_ff, den_ff;
   logic [15:0] clip;
   logic [15:0] span;
   logic        div_start, div_busy;
   logic [45:0] div_dividend, quotient;
   logic signed [15:0] ox_ff, oy_ff;
   logic signed [16:0] neg_q;

   assign sq_x = x * x;
   assign sq_y = y * y;
   assign dz_sq = deadzone * deadzone;

   always_comb begin
      trial = {rem_ff, sum_ff[31:30]} - {17'd0, root_ff, 2'b01};
      rem_in = rem_ff;
      root_in = root_ff;
      if (!trial[35]) begin
         rem_in = trial[33:0];
         root_in = {root_ff[15:0], 1'b1};
      end else begin
         rem_in = {rem_ff[31:0], sum_ff[31:30]};
         root_in = {root_ff[15:0], 1'b0};
      end
   end

   assign clip = (root_ff > 17'd32767) ? 16'd32767 : root_ff[15:0];
   assign span = 16'd32767 - {1'b0, dz_ff};

   always_comb begin
      state_in = state_ff;
      div_start = 1'b0;
      div_dividend = '0;
      unique case (state_ff)
         SL_IDLE: if (ctl.start) state_in = SL_SQRT;
         SL_SQRT: begin
            if (!active_ff) state_in = SL_DONE;
            else if (step_ff == 5'd16) state_in = SL_DEN;
         end
         SL_DEN: begin
            if (zero_ff || span == 16'd0 || root_ff == 17'd0 || clip <= {1'b0, dz_ff}) begin
               state_in = SL_DONE;
            end else begin
               div_start = 1'b1;
               div_dividend = {15'd0, mag_x_ff} * {15'd0, num_ff};
               state_in = SL_DIVX;
            end
         end
         SL_DIVX: if (!div_busy) begin
            div_start = 1'b1;
            div_dividend = {15'd0, mag_y_ff} * {15'd0, num_ff};
            state_in = SL_DIVY;
         end
         SL_DIVY: if (!div_busy) state_in = SL_DONE;
         SL_DONE: state_in = SL_IDLE;
         default: state_in = SL_IDLE;
      endcase
   end

   assign neg_q = -$signed({1'b0, quotient[15:0]});

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SL_IDLE;
      end else begin
         state_ff <= state_in;
      end
      if (ctl.start) begin
         mag_x_ff <= x[15] ? 16'(-x) : x;
         mag_y_ff <= y[15] ? 16'(-y) : y;
         neg_x_ff <= x[15];
         neg_y_ff <= y[15];
         sum_ff <= {1'b0, sq_x} + {1'b0, sq_y};
         active_ff <= ({1'b0, sq_x} + {1'b0, sq_y}) > {3'd0, dz_sq};
         dz_ff <= deadzone;
         rem_ff <= '0;
         root_ff <= '0;
         step_ff <= '0;
         zero_ff <= 1'b0;
         ox_ff <= '0;
         oy_ff <= '0;
      end else if (state_ff == SL_SQRT && active_ff && step_ff != 5'd16) begin
         rem_ff <= rem_in;
         root_ff <= root_in;
         sum_ff <= {sum_ff[30:0], 2'b00};
         step_ff <= step_ff + 5'd1;
      end else if (state_ff == SL_SQRT && step_ff == 5'd16) begin
         num_ff <= {15'd0, clip - {1'b0, dz_ff}} * 31'd32767;
         den_ff <= {14'd0, root_ff} * {15'd0, span};
         zero_ff <= 1'b0;
      end else if (state_ff == SL_DIVX && !div_busy) begin
         ox_ff <= neg_x_ff ? neg_q[15:0] : quotient[15:0];
      end else if (state_ff == SL_DIVY && !div_busy) begin
         oy_ff <= neg_y_ff ? neg_q[15:0] : quotient[15:0];
      end
   end

   grdc_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (den_ff),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign sts.done = (state_ff == SL_DONE);
   assign sts.active = active_ff;
   assign out_x = ox_ff;
   assign out_y = oy_ff;
endmodule

### hdl/grdc_trigger_lane.sv
`timescale 1ns / 1ps
module grdc_trigger_lane (
   input  logic                   clock,
   input  logic                   reset,
   input  grdc_pkg::lane_ctl_type ctl,
   input  logic [7:0]             level,
   input  logic [7:0]             threshold,
   output grdc_pkg::lane_sts_type sts,
   output logic [14:0]            out_level
);
   import grdc_pkg::*;

   logic [22:0] rem_ff, rem_in;
   logic [22:0] num_ff, num_in;
   logic [7:0]  den_ff;
   logic [4:0]  count_ff, count_in;
   logic        active_ff;
   logic        busy_ff, busy_in;
   logic        done_ff;
   logic [23:0] trial;

   always_comb begin
      trial = {rem_ff, num_ff[22]} - {16'd0, den_ff};
      rem_in = rem_ff;
      num_in = num_ff;
      count_in = count_ff;
      busy_in = busy_ff;
      if (busy_ff) begin
         count_in = count_ff - 5'd1;
         if (!trial[23]) begin
            rem_in = trial[22:0];
            num_in = {num_ff[21:0], 1'b1};
         end else begin
            rem_in = {rem_ff[21:0], num_ff[22]};
            num_in = {num_ff[21:0], 1'b0};
         end
         if (count_ff == 5'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         count_ff <= '0;
      end else if (ctl.start) begin
         busy_ff <= level > threshold;
         done_ff <= level <= threshold;
         count_ff <= 5'd23;
      end else begin
         busy_ff <= busy_in;
         count_ff <= count_in;
         done_ff <= busy_ff && !busy_in;
      end
      if (ctl.start) begin
         active_ff <= level > threshold;
         rem_ff <= '0;
         num_ff <= (level > threshold) ? {15'd0, 8'(level - threshold)} * 23'd32767 : 23'd0;
         den_ff <= 8'(TRIG_MAX) - threshold;
      end else begin
         rem_ff <= rem_in;
         num_ff <= num_in;
      end
   end

   assign sts.done = done_ff;
   assign sts.active = active_ff;
   assign out_level = num_ff[14:0];
endmodule

### hdl/gamepad_radial_deadzone_conditioner.sv
`timescale 1ns / 1ps
// The result beat is registered into held state once every lane has finished; a poll with
// no controller present skips the lanes and goes straight to the result state.
// One beat at a time: a new request is taken only after the result beat is accepted. An
// active stick runs a 16-step root and then two 46-step divides.
// Both sticks and both triggers run in parallel lanes, then merge into held state.
// Reset is synchronous, active high; held values clear and registers take defaults.
module gamepad_radial_deadzone_conditioner (
   input  logic                                 clock,
   input  logic                                 reset,
   grdc_if.sink                                 req,
   grdc_if.source                               rsp,
   input  logic                                 csr_write,
   input  logic [grdc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [grdc_pkg::CSR_DATA_W-1:0]      csr_data
);
   import grdc_pkg::*;

   top_state_type state_ff, state_in;
   logic [14:0] left_dz_ff, right_dz_ff;
   logic [7:0]  thr_ff;
   req_type     req_ff;
   rsp_type     held_ff;
   logic [3:0]  done_ff;
   lane_ctl_type ctl;
   lane_sts_type sl_sts, sr_sts, tl_sts, tr_sts;
   logic signed [15:0] lx, ly, rx, ry;
   logic [14:0] lt, rt;
   logic        all_done, chg;

   assign ctl.start = (state_ff == ST_IDLE) && req.valid && req.payload.present;
   assign all_done = &(done_ff | {sl_sts.done, sr_sts.done, tl_sts.done, tr_sts.done});

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req.valid) state_in = req.payload.present ? ST_RUN : ST_OUT;
         ST_RUN:  if (all_done) state_in = ST_OUT;
         ST_OUT:  if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      chg = !held_ff.connected
         || sl_sts.active || held_ff.left_x != 0 || held_ff.left_y != 0
         || sr_sts.active || held_ff.right_x != 0 || held_ff.right_y != 0
         || tl_sts.active || held_ff.left_trigger != 0
         || tr_sts.active || held_ff.right_trigger != 0
         || req_ff.raw_buttons != held_ff.buttons;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         left_dz_ff <= LEFT_DZ_RESET;
         right_dz_ff <= RIGHT_DZ_RESET;
         thr_ff <= TRIG_THR_RESET;
         held_ff <= '0;
         done_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_LEFT_DZ:  left_dz_ff <= csr_data;
               CSR_RIGHT_DZ: right_dz_ff <= csr_data;
               CSR_TRIG_THR: thr_ff <= csr_data[7:0];
               default: ;
            endcase
         end
         if (state_ff == ST_IDLE && req.valid) begin
            req_ff <= req.payload;
            done_ff <= '0;
            if (!req.payload.present) begin
               held_ff.changed <= held_ff.connected;
               held_ff.connected <= 1'b0;
            end
         end else if (state_ff == ST_RUN) begin
            done_ff <= done_ff | {sl_sts.done, sr_sts.done, tl_sts.done, tr_sts.done};
            if (all_done) begin
               held_ff.changed <= chg;
               held_ff.connected <= 1'b1;
               held_ff.left_x <= lx;
               held_ff.left_y <= ly;
               held_ff.right_x <= rx;
               held_ff.right_y <= ry;
               held_ff.left_trigger <= lt;
               held_ff.right_trigger <= rt;
               held_ff.buttons <= req_ff.raw_buttons;
            end
         end
      end
   end

   grdc_stick_lane u_left (
      .clock(clock), .reset(reset), .ctl(ctl),
      .x(req.payload.raw_left_x), .y(req.payload.raw_left_y), .deadzone(left_dz_ff),
      .sts(sl_sts), .out_x(lx), .out_y(ly));

   grdc_stick_lane u_right (
      .clock(clock), .reset(reset), .ctl(ctl),
      .x(req.payload.raw_right_x), .y(req.payload.raw_right_y), .deadzone(right_dz_ff),
      .sts(sr_sts), .out_x(rx), .out_y(ry));

   grdc_trigger_lane u_ltrig (
      .clock(clock), .reset(reset), .ctl(ctl),
      .level(req.payload.raw_left_trigger), .threshold(thr_ff),
      .sts(tl_sts), .out_level(lt));

   grdc_trigger_lane u_rtrig (
      .clock(clock), .reset(reset), .ctl(ctl),
      .level(req.payload.raw_right_trigger), .threshold(thr_ff),
      .sts(tr_sts), .out_level(rt));

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_OUT);
   assign rsp.payload = held_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("ready and valid overlap");
   a_run_follows: assert property (@(posedge clock) disable iff (reset)
      (ctl.start) |=> (state_ff == ST_RUN)) else $error("lanes started without run");
   a_absent_clears: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && !req.payload.present) |=> !held_ff.connected)
      else $error("connection not cleared");
endmodule

### tb/tb_gamepad_radial_deadzone_conditioner.sv
`timescale 1ns / 1ps
module tb_gamepad_radial_deadzone_conditioner;
   import grdc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_LEFT_DZ;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   grdc_if #(.payload_type(req_type)) req_ch ();
   grdc_if #(.payload_type(rsp_type)) rsp_ch ();

   gamepad_radial_deadzone_conditioner DUT (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   localparam int WATCHDOG_LIMIT = 20000;

   rsp_type expected_polls[$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit recv_hold = 1'b0;
   int mismatches = 0;
   int polls_sent = 0;
   int polls_checked = 0;
   int active_sticks = 0;
   int quiet_cycles = 0;

   logic [14:0] left_dz;
   logic [14:0] right_dz;
   logic [7:0] trig_thr;
   rsp_type held;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
   end

   function automatic logic [31:0] isqrt(input logic [32:0] s);
      logic [31:0] r;
      logic [63:0] t;
      r = 0;
      for (int b = 16; b >= 0; b--) begin
         t = r | (32'd1 << b);
         if (t * t <= s)
            r = t;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] scale_axis(input logic signed [15:0] v,
         input logic [63:0] num, input logic [63:0] den);
      logic [63:0] mag;
      logic [63:0] q;
      mag = v < 0 ? 64'(-32'(v)) : 64'(32'(v));
      q = (mag * num) / den;
      return v < 0 ? -16'(q) : 16'(q);
   endfunction

   function automatic bit condition_stick(input logic signed [15:0] x,
         input logic signed [15:0] y, input logic [14:0] dz,
         output logic signed [15:0] ox, output logic signed [15:0] oy);
      logic [32:0] s;
      logic [63:0] d;
      logic [63:0] len;
      logic [63:0] clip;
      logic [63:0] span;
      s = 33'($signed(32'(x)) * $signed(32'(x))) + 33'($signed(32'(y)) * $signed(32'(y)));
      d = 64'(dz);
      ox = 0;
      oy = 0;
      if (64'(s) <= d * d)
         return 1'b0;
      len = 64'(isqrt(s));
      clip = len > FULL_SCALE ? FULL_SCALE : len;
      span = FULL_SCALE - d;
      if (span == 0 || len == 0 || clip <= d)
         return 1'b1;
      ox = scale_axis(x, (clip - d) * FULL_SCALE, len * span);
      oy = scale_axis(y, (clip - d) * FULL_SCALE, len * span);
      return 1'b1;
   endfunction

   function automatic bit condition_trigger(input logic [7:0] t, input logic [7:0] thr,
         output logic [14:0] level);
      level = 0;
      if (t <= thr)
         return 1'b0;
      level = 15'(((32'(t) - thr) * FULL_SCALE) / (TRIG_MAX - thr));
      return 1'b1;
   endfunction

   function automatic rsp_type predict_poll(input req_type p);
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic [14:0] tv;
      bit chg;
      if (!p.present) begin
         chg = held.connected;
         held.connected = 1'b0;
      end else begin
         chg = !held.connected;
         held.connected = 1'b1;
         if (condition_stick(p.raw_left_x, p.raw_left_y, left_dz, ax, ay)) begin
            chg = 1'b1;
            active_sticks++;
         end else if (held.left_x != 0 || held.left_y != 0) begin
            chg = 1'b1;
         end
         held.left_x = ax;
         held.left_y = ay;
         if (condition_stick(p.raw_right_x, p.raw_right_y, right_dz, ax, ay)) begin
            chg = 1'b1;
            active_sticks++;
         end else if (held.right_x != 0 || held.right_y != 0) begin
            chg = 1'b1;
         end
         held.right_x = ax;
         held.right_y = ay;
         if (condition_trigger(p.raw_left_trigger, trig_thr, tv) || held.left_trigger != 0)
            chg = 1'b1;
         held.left_trigger = tv;
         if (condition_trigger(p.raw_right_trigger, trig_thr, tv) || held.right_trigger != 0)
            chg = 1'b1;
         held.right_trigger = tv;
         if (p.raw_buttons != held.buttons)
            chg = 1'b1;
         held.buttons = p.raw_buttons;
      end
      held.changed = chg;
      return held;
   endfunction

   task automatic send_poll(input req_type p);
      while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      expected_polls = {expected_polls, predict_poll(p)};
      req_ch.payload <= p;
      req_ch.valid <= 1'b1;
      do
         @(posedge clock);
      while (!req_ch.ready);
      polls_sent++;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [14:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      case (idx)
         CSR_LEFT_DZ: begin
            left_dz = value;
         end
         CSR_RIGHT_DZ: begin
            right_dz = value;
         end
         default: begin
            trig_thr = value[7:0];
         end
      endcase
   endtask

   task automatic drain;
      req_ch.valid <= 1'b0;
      while (expected_polls.size() != 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic configure(input logic [14:0] ldz, input logic [14:0] rdz,
         input logic [7:0] thr);
      drain();
      write_csr(CSR_LEFT_DZ, ldz);
      write_csr(CSR_RIGHT_DZ, rdz);
      write_csr(CSR_TRIG_THR, 15'(thr));
      csr_write <= 1'b0;
   endtask

   function automatic req_type make_poll(input bit pres, input int lx, input int ly,
         input int rx, input int ry, input int lt, input int rt, input int btn);
      req_type p;
      p.present = pres;
      p.raw_left_x = 16'(lx);
      p.raw_left_y = 16'(ly);
      p.raw_right_x = 16'(rx);
      p.raw_right_y = 16'(ry);
      p.raw_left_trigger = 8'(lt);
      p.raw_right_trigger = 8'(rt);
      p.raw_buttons = 16'(btn);
      return p;
   endfunction

   function automatic int random_axis();
      case ($urandom_range(5))
         0: return $urandom_range(65535) - 32768;
         1: return $urandom_range(1) ? 32767 : -32768;
         2: return $urandom_range(2000) - 1000;
         default: return $urandom_range(40000) - 20000;
      endcase
   endfunction

   function automatic req_type random_poll();
      req_type p;
      p = make_poll($urandom_range(9) != 0, random_axis(), random_axis(),
         random_axis(), random_axis(), $urandom_range(255), $urandom_range(255),
         $urandom_range(65535));
      if ($urandom_range(3) == 0)
         p.raw_buttons = held.buttons;
      return p;
   endfunction

   task automatic test_directed_extremes;
      send_poll(make_poll(1, 0, 0, 0, 0, 0, 0, 0));
      send_poll(make_poll(1, -32768, -32768, 32767, 32767, 255, 255, 16'hFFFF));
      send_poll(make_poll(1, 32767, 0, 0, -32768, 31, 30, 16'hFFFF));
      send_poll(make_poll(1, 7849, 0, 0, 8690, 30, 29, 16'h5555));
      send_poll(make_poll(1, 7850, 0, 0, 8689, 0, 0, 16'hAAAA));
      send_poll(make_poll(0, 100, 100, 100, 100, 100, 100, 16'h1234));
      send_poll(make_poll(0, 0, 0, 0, 0, 0, 0, 0));
      send_poll(make_poll(1, 20000, -20000, -5000, 30000, 128, 200, 16'h1234));
      send_poll(make_poll(1, 20000, -20000, -5000, 30000, 128, 200, 16'h1234));
      send_poll(make_poll(1, 0, 0, 0, 0, 0, 0, 16'h1234));
   endtask

   task automatic test_config_extremes;
      configure(15'd0, 15'd32766, 8'd0);
      send_poll(make_poll(1, 1, 0, 32767, 1, 1, 0, 1));
      send_poll(make_poll(1, -1, -1, -32768, -32768, 255, 1, 2));
      configure(15'd32767, 15'd32767, 8'd255);
      send_poll(make_poll(1, -32768, -32768, 32767, 32767, 255, 255, 3));
      send_poll(make_poll(1, 32767, 0, 0, 32767, 255, 0, 3));
      configure(15'd32766, 15'd1, 8'd254);
      send_poll(make_poll(1, -32768, 0, 0, 1, 255, 254, 4));
      send_poll(make_poll(1, 0, 0, 1, 1, 254, 255, 4));
   endtask

   task automatic test_random(input int count, input int s_pct, input int r_pct);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      repeat (count) send_poll(random_poll());
   endtask

   task automatic test_backpressure;
      recv_idle_pct = 0;
      send_idle_pct = 0;
      recv_hold = 1'b1;
      fork
         repeat (12) send_poll(random_poll());
         begin
            repeat (1500) @(posedge clock);
            recv_hold = 1'b0;
         end
      join
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= !recv_hold && !(recv_idle_pct != 0 &&
            $urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_polls.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected beat on the result channel: %p", rsp_ch.payload);
         end else begin
            want = expected_polls.pop_front();
            polls_checked++;
            if (rsp_ch.payload !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch on poll %0d: expected %p, got %p",
                     polls_checked, want, rsp_ch.payload);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || recv_hold)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired with %0d polls outstanding", expected_polls.size());
         $display("tb_gamepad_radial_deadzone_conditioner failed");
         $finish;
      end
   end

   initial begin
      held = '0;
      left_dz = LEFT_DZ_RESET;
      right_dz = RIGHT_DZ_RESET;
      trig_thr = TRIG_THR_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_extremes();
      test_config_extremes();
      configure(LEFT_DZ_RESET, RIGHT_DZ_RESET, TRIG_THR_RESET);
      test_random(200, 37, 64);
      test_backpressure();
      configure(15'($urandom_range(32766)), 15'($urandom_range(12000)),
         8'($urandom_range(254)));
      test_random(200, 64, 37);
      configure(15'd3000, 15'd0, 8'd100);
      test_random(200, 0, 0);
      drain();
      $display("Checked %0d of %0d polls, %0d active sticks, across six register settings.",
         polls_checked, polls_sent, active_sticks);
      if (mismatches == 0 && expected_polls.size() == 0) begin
         $display("tb_gamepad_radial_deadzone_conditioner passed");
      end else begin
         $display("%0d mismatches, %0d polls never answered", mismatches,
            expected_polls.size());
         $display("tb_gamepad_radial_deadzone_conditioner failed");
      end
      $finish;
   end

endmodule
